@@ sv/mbd_pkg.sv @@
// ----------------------------------------------------------------------------
// Manchester bit decoder package
// Shared widths, payload types, event descriptor and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mbd_pkg;

  localparam int unsigned FrameBits  = 64;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned IntervalW  = 10;
  localparam int unsigned IndexW     = 6;
  localparam int unsigned CfgIdxW    = 3;

  typedef logic [IntervalW-1:0] tick_t;
  typedef logic [IndexW-1:0]    index_t;
  typedef logic [CfgIdxW-1:0]   cfg_idx_t;

  typedef struct packed {
    tick_t interval;
    logic  line_level;
  } in_t;

  typedef struct packed {
    logic   bit_value;
    index_t bit_index;
    logic   frame_end;
  } out_t;

  typedef struct packed {
    logic hdr;
    logic half;
    logic full;
    logic level;
  } ev_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GLITCH_MIN  = 3'd0,
    CFG_HEADER_LOW  = 3'd1,
    CFG_HEADER_HIGH = 3'd2,
    CFG_HALF_LOW    = 3'd3,
    CFG_HALF_HIGH   = 3'd4,
    CFG_FULL_LOW    = 3'd5,
    CFG_FULL_HIGH   = 3'd6
  } cfg_idx_e;

  localparam tick_t GlitchMinRst  = tick_t'(6);
  localparam tick_t HeaderLowRst  = tick_t'(320);
  localparam tick_t HeaderHighRst = tick_t'(380);
  localparam tick_t HalfLowRst    = tick_t'(35);
  localparam tick_t HalfHighRst   = tick_t'(72);
  localparam tick_t FullLowRst    = tick_t'(110);
  localparam tick_t FullHighRst   = tick_t'(160);

  localparam index_t LastIndex = index_t'(FrameBits - 1);

endpackage

`default_nettype wire

@@ sv/mbd_front.sv @@
// ----------------------------------------------------------------------------
// Manchester bit decoder front end
// Holds the window registers and classifies each edge interval.
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  input  wire mbd_pkg::cfg_idx_t cfg_index_i,
  input  wire mbd_pkg::tick_t   cfg_data_i,
  input  wire logic             in_valid_i,
  input  wire mbd_pkg::in_t     in_data_i,
  input  wire logic             q_full_i,
  output logic                  in_stall_o,
  output logic                  push_o,
  output mbd_pkg::ev_t          push_data_o
);
  import mbd_pkg::*;

  tick_t glitch_min_q, header_low_q, header_high_q;
  tick_t half_low_q, half_high_q, full_low_q, full_high_q;
  logic  pass_glitch;
  ev_t   ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glitch_min_q  <= GlitchMinRst;
      header_low_q  <= HeaderLowRst;
      header_high_q <= HeaderHighRst;
      half_low_q    <= HalfLowRst;
      half_high_q   <= HalfHighRst;
      full_low_q    <= FullLowRst;
      full_high_q   <= FullHighRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GLITCH_MIN:  glitch_min_q  <= cfg_data_i;
        CFG_HEADER_LOW:  header_low_q  <= cfg_data_i;
        CFG_HEADER_HIGH: header_high_q <= cfg_data_i;
        CFG_HALF_LOW:    half_low_q    <= cfg_data_i;
        CFG_HALF_HIGH:   half_high_q   <= cfg_data_i;
        CFG_FULL_LOW:    full_low_q    <= cfg_data_i;
        CFG_FULL_HIGH:   full_high_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    pass_glitch = in_data_i.interval >= glitch_min_q;
    ev.hdr   = pass_glitch && (in_data_i.interval > header_low_q)
               && (in_data_i.interval < header_high_q);
    ev.half  = pass_glitch && (in_data_i.interval > half_low_q)
               && (in_data_i.interval < half_high_q);
    ev.full  = pass_glitch && (in_data_i.interval > full_low_q)
               && (in_data_i.interval < full_high_q);
    ev.level = in_data_i.line_level;
  end

  assign in_stall_o  = q_full_i;
  assign push_o      = in_valid_i && !q_full_i && (ev.hdr || ev.half || ev.full);
  assign push_data_o = ev;

endmodule

`default_nettype wire

@@ sv/mbd_queue.sv @@
// ----------------------------------------------------------------------------
// Manchester bit decoder event queue
// Short FIFO of classified events between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire mbd_pkg::ev_t push_data_i,
  input  wire logic         pop_i,
  output logic              full_o,
  output logic              valid_o,
  output mbd_pkg::ev_t      data_o
);
  import mbd_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  ev_t             mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o  = cnt_q == FullCnt;
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

@@ sv/mbd_back.sv @@
// ----------------------------------------------------------------------------
// Manchester bit decoder back end
// Tracks frame state, pairs half-bit levels and registers decoded bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         q_valid_i,
  input  wire mbd_pkg::ev_t q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output mbd_pkg::out_t     out_data_o
);
  import mbd_pkg::*;

  logic   active_q, active_d;
  logic   pending_q, pending_d;
  logic   held_q, held_d;
  index_t cnt_q, cnt_d;
  logic   out_valid_q, out_valid_d;
  out_t   out_data_q, out_data_d;
  logic   do_close, emit, last;

  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);
  assign last  = cnt_q == LastIndex;

  always_comb begin
    active_d  = active_q;
    pending_d = pending_q;
    held_d    = held_q;
    cnt_d     = cnt_q;
    do_close  = 1'b0;
    if (pop_o) begin
      priority if (!active_q) begin
        if (q_data_i.hdr) begin
          active_d = 1'b1;
        end
      end else if (q_data_i.half) begin
        if (!pending_q) begin
          held_d    = q_data_i.level;
          pending_d = 1'b1;
        end else begin
          pending_d = 1'b0;
          do_close  = 1'b1;
        end
      end else if (q_data_i.full) begin
        do_close  = pending_q;
        pending_d = 1'b1;
        held_d    = q_data_i.level;
      end else begin
      end
    end
    emit = do_close && (held_q != q_data_i.level);
    if (emit) begin
      if (last) begin
        active_d  = 1'b0;
        pending_d = 1'b0;
        cnt_d     = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    if (emit) begin
      out_valid_d          = 1'b1;
      out_data_d.bit_value = held_q;
      out_data_d.bit_index = cnt_q;
      out_data_d.frame_end = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      pending_q   <= 1'b0;
      held_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      pending_q   <= pending_d;
      held_q      <= held_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_pending_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> !pending_q)
    else $error("half-bit level held outside a frame");

  a_frame_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last) |=> (!active_q && cnt_q == '0))
    else $error("frame state not cleared after last bit");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !last) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("bit count did not advance by one");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || !out_stall_i))
    else $error("decoded bit overwrote a waiting result");

endmodule

`default_nettype wire

@@ sv/manchester_bit_decoder_core.sv @@
// ----------------------------------------------------------------------------
// Manchester bit decoder core
// Pulse-width Manchester decoder driven by edge events.
// ----------------------------------------------------------------------------
// A decoded bit passes through the event queue and then the output register.
// Throughput: one edge word per cycle, set by the back end update, unless a full event queue stalls the input.
// The two-entry event queue lets the input run while a result waits.
// Reset clears frame state and restores every window register to its default.
// No clearing pass follows reset; the block accepts words at once.
`default_nettype none

module manchester_bit_decoder_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire mbd_pkg::cfg_idx_t cfg_index_i,
  input  wire mbd_pkg::tick_t    cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire mbd_pkg::in_t      in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output mbd_pkg::out_t          out_data_o
);
  import mbd_pkg::*;

  logic q_full, q_valid, push, pop;
  ev_t  push_data, q_data;

  assign cfg_ready_o = 1'b1;

  mbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .push_data_o (push_data)
  );

  mbd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  mbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ tb/manchester_bit_decoder_checker.sv @@
// ----------------------------------------------------------------------------
// Manchester bit decoder checker
// Watches the configuration, edge and bit channels of the decoder. It keeps
// its own copy of the window registers and frame state, works out the bit
// word, if any, that each accepted edge word should produce, and compares every
// accepted bit word field by field with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module manchester_bit_decoder_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  mbd_pkg::cfg_idx_t cfg_index_i,
  input  mbd_pkg::tick_t    cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  mbd_pkg::in_t      in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  mbd_pkg::out_t     out_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import mbd_pkg::*;

  tick_t  noise_floor;
  tick_t  hdr_lo;
  tick_t  hdr_hi;
  tick_t  half_lo;
  tick_t  half_hi;
  tick_t  full_lo;
  tick_t  full_hi;

  logic   in_frame;
  logic   first_half_held;
  logic   first_half_level;
  index_t bits_done;

  out_t   expected_bits [$];

  function automatic logic strictly_between(input tick_t v, input tick_t lo, input tick_t hi);
    return (v > lo) && (v < hi);
  endfunction

  task automatic store_reg(input cfg_idx_t idx, input tick_t val);
    unique case (cfg_idx_e'(idx))
      CFG_GLITCH_MIN:  noise_floor = val;
      CFG_HEADER_LOW:  hdr_lo = val;
      CFG_HEADER_HIGH: hdr_hi = val;
      CFG_HALF_LOW:    half_lo = val;
      CFG_HALF_HIGH:   half_hi = val;
      CFG_FULL_LOW:    full_lo = val;
      CFG_FULL_HIGH:   full_hi = val;
      default: ;
    endcase
  endtask

  task automatic pair_levels(input logic level);
    out_t b;
    if (first_half_level == level) return;
    b.bit_value = first_half_level;
    b.bit_index = bits_done;
    b.frame_end = (bits_done == LastIndex);
    expected_bits.push_back(b);
    if (b.frame_end) begin
      in_frame = 1'b0;
      first_half_held = 1'b0;
      bits_done = '0;
    end else begin
      bits_done = bits_done + 1'b1;
    end
  endtask

  task automatic decode_edge(input in_t w);
    if (w.interval < noise_floor) return;
    if (!in_frame) begin
      if (strictly_between(w.interval, hdr_lo, hdr_hi)) in_frame = 1'b1;
      return;
    end
    if (strictly_between(w.interval, half_lo, half_hi)) begin
      if (!first_half_held) begin
        first_half_level = w.line_level;
        first_half_held = 1'b1;
      end else begin
        first_half_held = 1'b0;
        pair_levels(w.line_level);
      end
    end else if (strictly_between(w.interval, full_lo, full_hi)) begin
      if (first_half_held) pair_levels(w.line_level);
      if (in_frame) first_half_held = 1'b1;
      first_half_level = w.line_level;
    end
  endtask

  task automatic check_bit(input out_t got);
    out_t want;
    if (expected_bits.size() == 0) begin
      $error("bit word with none outstanding: bit_value %0d, bit_index %0d, frame_end %0d",
             got.bit_value, got.bit_index, got.frame_end);
      fail_count_o++;
      return;
    end
    want = expected_bits.pop_front();
    if (got.bit_value !== want.bit_value) begin
      $error("bit_value: expected %0d, actual %0d", want.bit_value, got.bit_value);
      fail_count_o++;
    end
    if (got.bit_index !== want.bit_index) begin
      $error("bit_index: expected %0d, actual %0d", want.bit_index, got.bit_index);
      fail_count_o++;
    end
    if (got.frame_end !== want.frame_end) begin
      $error("frame_end: expected %0d, actual %0d", want.frame_end, got.frame_end);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_floor = GlitchMinRst;
      hdr_lo = HeaderLowRst;
      hdr_hi = HeaderHighRst;
      half_lo = HalfLowRst;
      half_hi = HalfHighRst;
      full_lo = FullLowRst;
      full_hi = FullHighRst;
      in_frame = 1'b0;
      first_half_held = 1'b0;
      first_half_level = 1'b0;
      bits_done = '0;
      expected_bits.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) store_reg(cfg_index_i, cfg_data_i);
      if (out_valid_i && !out_stall_i) check_bit(out_data_i);
      if (in_valid_i && !in_stall_i) decode_edge(in_data_i);
      pending_o = expected_bits.size();
    end
  end

endmodule

@@ tb/manchester_bit_decoder_core_tb.sv @@
// ----------------------------------------------------------------------------
// Manchester bit decoder testbench
// Drives edge words into the decoder under several window settings: a short
// directed sequence first, then random frames built mostly from well-formed
// half-bit pairs with noise and broken pairs mixed in. The sender works in
// bursts, the receiver stalls on its own pattern, and a separate checker
// predicts and compares every decoded bit word.
// ----------------------------------------------------------------------------
module manchester_bit_decoder_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import mbd_pkg::*;

  localparam int unsigned ClkPeriod    = 20;
  localparam int unsigned ResetCycles  = 11;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned CycleLimit   = 200000;
  localparam cfg_idx_t    CfgNoReg     = cfg_idx_t'(7);

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  cfg_idx_t cfg_index_i = CFG_GLITCH_MIN;
  tick_t    cfg_data_i  = '0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  in_t      in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_t     out_data_o;

  int unsigned fail_count;
  int unsigned pending_bits;
  int unsigned cycle_count   = 0;
  int unsigned words_sent    = 0;
  int unsigned burst_left    = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done    = 0;
  tick_t       cfg_shadow [0:6];

  manchester_bit_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  manchester_bit_decoder_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_bits)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic in_t edge_word(input tick_t ticks, input logic level);
    in_t w;
    w.interval = ticks;
    w.line_level = level;
    return w;
  endfunction

  function automatic tick_t pick_in_window(input tick_t lo, input tick_t hi);
    if (hi > lo + 1) return tick_t'($urandom_range(hi - 1, lo + 1));
    return tick_t'($urandom_range(1023, 0));
  endfunction

  task automatic send_word(input in_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_bits != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input tick_t val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx <= CFG_FULL_HIGH) cfg_shadow[idx] = val;
  endtask

  task automatic send_windowed(input cfg_idx_e lo_reg, input cfg_idx_e hi_reg,
                               input logic level);
    send_word(edge_word(pick_in_window(cfg_shadow[lo_reg], cfg_shadow[hi_reg]), level));
  endtask

  task automatic send_frame(input int unsigned limit);
    int unsigned steps;
    int unsigned pick;
    logic        lvl;
    tick_t       floor_ticks;
    steps = $urandom_range(100, 70);
    send_windowed(CFG_HEADER_LOW, CFG_HEADER_HIGH, logic'($urandom_range(1, 0)));
    repeat (steps) begin
      if (words_sent >= limit) break;
      lvl = logic'($urandom_range(1, 0));
      pick = $urandom_range(19, 0);
      if (pick < 15) begin
        send_windowed(CFG_HALF_LOW, CFG_HALF_HIGH, lvl);
        send_windowed(CFG_HALF_LOW, CFG_HALF_HIGH, !lvl);
      end else if (pick == 15) begin
        send_windowed(CFG_HALF_LOW, CFG_HALF_HIGH, lvl);
        send_windowed(CFG_HALF_LOW, CFG_HALF_HIGH, lvl);
      end else if (pick == 16) begin
        send_windowed(CFG_FULL_LOW, CFG_FULL_HIGH, lvl);
      end else if (pick == 17) begin
        floor_ticks = cfg_shadow[CFG_GLITCH_MIN];
        send_word(edge_word((floor_ticks != 0) ?
                            tick_t'($urandom_range(floor_ticks - 1, 0)) : '0, lvl));
      end else if (pick == 18) begin
        send_word(edge_word(tick_t'($urandom_range(1023, 0)), lvl));
      end else begin
        send_windowed(CFG_HEADER_LOW, CFG_HEADER_HIGH, lvl);
      end
    end
  endtask

  task automatic run_phase(input tick_t g, input tick_t hl, input tick_t hh,
                           input tick_t ql, input tick_t qh, input tick_t fl,
                           input tick_t fh, input int unsigned budget);
    int unsigned target;
    drain();
    write_reg(CFG_GLITCH_MIN, g);
    write_reg(CFG_HEADER_LOW, hl);
    write_reg(CFG_HEADER_HIGH, hh);
    write_reg(CFG_HALF_LOW, ql);
    write_reg(CFG_HALF_HIGH, qh);
    write_reg(CFG_FULL_LOW, fl);
    write_reg(CFG_FULL_HIGH, fh);
    target = words_sent + budget;
    while (words_sent < target) send_frame(target);
  endtask

  initial begin : receiver
    int unsigned seg;
    int unsigned mode;
    forever begin
      seg = $urandom_range(60, 5);
      mode = $urandom_range(3, 0);
      repeat (seg) begin
        @(negedge clk_i);
        if (hold_requests != holds_done) begin
          out_stall_i <= 1'b1;
          repeat (HoldCycles) @(negedge clk_i);
          holds_done++;
        end
        unique case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= logic'($urandom_range(1, 0));
          2: out_stall_i <= ($urandom_range(3, 0) != 0);
          default: out_stall_i <= ($urandom_range(7, 0) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned target;
    cfg_shadow[CFG_GLITCH_MIN] = GlitchMinRst;
    cfg_shadow[CFG_HEADER_LOW] = HeaderLowRst;
    cfg_shadow[CFG_HEADER_HIGH] = HeaderHighRst;
    cfg_shadow[CFG_HALF_LOW] = HalfLowRst;
    cfg_shadow[CFG_HALF_HIGH] = HalfHighRst;
    cfg_shadow[CFG_FULL_LOW] = FullLowRst;
    cfg_shadow[CFG_FULL_HIGH] = FullHighRst;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_word(edge_word(10'd0, 1'b0));
    send_word(edge_word(10'd5, 1'b1));
    send_word(edge_word(10'd1023, 1'b1));
    send_word(edge_word(10'd320, 1'b0));
    send_word(edge_word(10'd380, 1'b1));
    send_word(edge_word(10'd321, 1'b1));
    send_word(edge_word(10'd36, 1'b1));
    send_word(edge_word(10'd71, 1'b0));
    send_word(edge_word(10'd50, 1'b0));
    send_word(edge_word(10'd50, 1'b0));
    send_word(edge_word(10'd40, 1'b0));
    send_word(edge_word(10'd120, 1'b1));
    send_word(edge_word(10'd159, 1'b0));
    send_word(edge_word(10'd35, 1'b1));
    send_word(edge_word(10'd72, 1'b0));
    send_word(edge_word(10'd110, 1'b1));
    send_word(edge_word(10'd160, 1'b0));
    send_word(edge_word(10'd350, 1'b1));
    send_word(edge_word(10'd1023, 1'b0));
    send_word(edge_word(10'd60, 1'b1));
    send_word(edge_word(10'd130, 1'b1));
    send_word(edge_word(10'd40, 1'b0));

    target = words_sent + 375;
    while (words_sent < target) send_frame(target);

    drain();
    write_reg(CfgNoReg, tick_t'($urandom_range(1023, 0)));
    run_phase(10'd0, 10'd0, 10'd1023, 10'd20, 10'd60, 10'd90, 10'd200, 400);
    run_phase(10'd1023, 10'd320, 10'd380, 10'd35, 10'd72, 10'd110, 10'd160, 80);
    hold_requests++;
    run_phase(10'd15, 10'd200, 10'd260, 10'd30, 10'd150, 10'd100, 10'd200, 300);
    run_phase(10'd6, 10'd400, 10'd500, 10'd50, 10'd51, 10'd0, 10'd1023, 150);
    run_phase(10'd2, 10'd1000, 10'd1023, 10'd2, 10'd9, 10'd9, 10'd30, 250);

    drain();
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
